### design/mematch_pkg.sv
// Package for the MIDI event match table: field widths, commands,
// event type codes, the stored entry layout and the entry compare function.
// No dependencies.
package mematch_pkg;

  localparam int CMD_W       = 1;
  localparam int IDX_W       = 5;
  localparam int TYPE_W      = 3;
  localparam int CODE_W      = 32;
  localparam int CHAN_W      = 5;
  localparam int MAP_W       = 32;
  localparam int ENTRIES_DEF = 32;

  // Commands carried by an input item
  localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_MATCH = 1'b1;

  // Event type codes
  localparam logic [TYPE_W-1:0] EV_NONE       = 3'd0;
  localparam logic [TYPE_W-1:0] EV_KEYBOARD   = 3'd1;
  localparam logic [TYPE_W-1:0] EV_NOTE       = 3'd2;
  localparam logic [TYPE_W-1:0] EV_CONTROLLER = 3'd3;
  localparam logic [TYPE_W-1:0] EV_OSC        = 3'd4;

  // Wildcard channel in a stored entry
  localparam logic [CHAN_W-1:0] CHAN_ANY = 5'd0;

  typedef struct packed {
    logic [TYPE_W-1:0] ev_type;
    logic [CODE_W-1:0] code;
    logic [CHAN_W-1:0] chan;
  } entry_t;

  // Decide whether one stored entry fires for an event
  function automatic logic slot_fires(
    input entry_t            ent,
    input logic [TYPE_W-1:0] ev_type,
    input logic [CODE_W-1:0] code,
    input logic [CHAN_W-1:0] chan
  );
    logic fires;
    fires = 1'b0;
    if (ent.ev_type == ev_type) begin
      case (ev_type) inside
        EV_KEYBOARD, EV_OSC: begin
          fires = (ent.code == code);
        end
        EV_NOTE, EV_CONTROLLER: begin
          fires = (ent.code == code) && ((ent.chan == CHAN_ANY) || (ent.chan == chan));
        end
        default: begin
          fires = 1'b0;
        end
      endcase
    end
    return fires;
  endfunction

endpackage

### design/midi_event_match_table.sv
// MIDI event match table: trigger entries in one synchronous memory, scanned
// one entry per cycle against a match event; depends on mematch_pkg.
// A write gives a zero result; a match gives its map of min(ENTRIES,32)
// entries, built as the single memory read port visits one entry per cycle.
// Throughput: one item at a time; the next is taken the cycle after the result
// enters the output register. Reset clears control and all entry valid bits at
// once (every entry reads as type none); no clearing pass is needed.
module midi_event_match_table
  import mematch_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [IDX_W-1:0]  in_entry_index,
  input  logic [TYPE_W-1:0] in_event_type,
  input  logic [CODE_W-1:0] in_event_code,
  input  logic [CHAN_W-1:0] in_event_channel,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [MAP_W-1:0]  out_match_map,
  output logic              out_any_match
);

  localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int XW   = (AW > IDX_W) ? AW : IDX_W;
  localparam int SCAN = (ENTRIES < MAP_W) ? ENTRIES : MAP_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SCAN - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic               in_acc;
  logic               in_range;
  logic               wr_en;
  logic               rd_en;
  logic               out_free;
  logic               load_out;
  logic [XW-1:0]      wr_ext;
  logic [XW-1:0]      rd_ext;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  entry_t             wr_entry;
  entry_t             mem [ENTRIES];
  entry_t             rd_data_r;
  logic               rd_vld_r;
  logic [ENTRIES-1:0] entry_vld_r;
  logic [IDX_W-1:0]   rd_cnt_r;
  logic [IDX_W-1:0]   cmp_idx_r;
  logic               rd_pend_r;
  logic [TYPE_W-1:0]  ev_type_r;
  logic [CODE_W-1:0]  ev_code_r;
  logic [CHAN_W-1:0]  ev_chan_r;
  logic [MAP_W-1:0]   map_r;
  logic               fire;
  logic               out_valid_r;
  logic [MAP_W-1:0]   out_match_map_r;
  logic               out_any_match_r;

  // Handshakes
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign load_out = (state_r == ST_DONE) && out_free;

  // Write port: drop writes beyond the table
  assign in_range = (32'(in_entry_index) < 32'(ENTRIES));
  assign wr_en    = in_acc && (in_command == CMD_WRITE) && in_range;
  assign wr_ext   = XW'(in_entry_index);
  assign wr_addr  = wr_ext[AW-1:0];
  assign wr_entry = '{ev_type: in_event_type, code: in_event_code, chan: in_event_channel};

  // Read port: one entry per cycle during the scan
  assign rd_en   = (state_r == ST_SCAN);
  assign rd_ext  = XW'(rd_cnt_r);
  assign rd_addr = rd_ext[AW-1:0];

  // Entry memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= entry_vld_r[rd_addr];
    end
  end

  // Valid bits: an entry never written reads as type none
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_vld_r <= '0;
    end else if (wr_en) begin
      entry_vld_r[wr_addr] <= 1'b1;
    end
  end

  // Compare the entry read last cycle
  assign fire = rd_vld_r && slot_fires(rd_data_r, ev_type_r, ev_code_r, ev_chan_r);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_command == CMD_WRITE) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_cnt_r == LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_cnt_r    <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_en;
      if (in_acc) begin
        rd_cnt_r <= '0;
      end else if (rd_en && (rd_cnt_r != LAST)) begin
        rd_cnt_r <= rd_cnt_r + IDX_W'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the event, build the map, load the result
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ev_type_r <= in_event_type;
      ev_code_r <= in_event_code;
      ev_chan_r <= in_event_channel;
      map_r     <= '0;
    end else if (rd_pend_r) begin
      map_r[cmp_idx_r] <= fire;
    end
    if (rd_en) begin
      cmp_idx_r <= rd_cnt_r;
    end
    if (load_out) begin
      out_match_map_r <= map_r;
      out_any_match_r <= |map_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_match_map = out_match_map_r;
  assign out_any_match = out_any_match_r;

`ifndef SYNTHESIS
  // The any flag agrees with the map it reports
  a_any_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_any_match_r == (out_match_map_r != '0)))
    else $error("any_match disagrees with match_map");

  // Compares happen only while a scan is running or draining
  a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> ((state_r == ST_SCAN) || (state_r == ST_DRAIN)))
    else $error("entry compare outside scan");

  // A write skips the scan and goes straight to result delivery
  a_write_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_command == CMD_WRITE)) |=> (state_r == ST_DONE))
    else $error("write item did not go to result delivery");

  // A scan reads the table without writing it
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !wr_en)
    else $error("table write during scan");
`endif

endmodule
